>>> hdl/phase_current_overcurrent_monitor_assert.svh
// Assertion macros for the phase current overcurrent monitor.
// Used by the merge stage; expects signals named clk and rst_n in scope.
`ifndef PHASE_CURRENT_OVERCURRENT_MONITOR_ASSERT_SVH
`define PHASE_CURRENT_OVERCURRENT_MONITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCOM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcom assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCOM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcom assertion failed");

`endif

>>> hdl/pcom_pkg.sv
// Shared types and constants for the phase current overcurrent monitor.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package pcom_pkg;

  // Data path sizing.
  localparam int ADC_BITS     = 12;
  localparam int CURRENT_BITS = 16;
  localparam int GAIN_W       = 16;
  localparam int FRAC_BITS    = 12;
  localparam int LIMIT_W      = 15;
  localparam int RUN_W        = 8;
  localparam int BLANK_W      = 16;
  localparam int STAMP_W      = 32;
  localparam int COUNT_W      = 32;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_PHASES   = 3;

  // Reset values of the configuration registers.
  localparam logic [ADC_BITS-1:0] OFFSET_RST = ADC_BITS'(2048);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(4096);
  localparam logic [RUN_W-1:0]    RUN_RST    = RUN_W'(1);

  // Request operation codes.
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_BLANK  = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NEW   = 3'd0,
    ST_HELD  = 3'd1,
    ST_ERR   = 3'd2,
    ST_TRIP  = 3'd3,
    ST_BLANK = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_A = 3'd0,
    CFG_OFFSET_B = 3'd1,
    CFG_OFFSET_C = 3'd2,
    CFG_GAIN_A   = 3'd3,
    CFG_GAIN_B   = 3'd4,
    CFG_GAIN_C   = 3'd5,
    CFG_LIMIT    = 3'd6,
    CFG_RUN_LEN  = 3'd7
  } cfg_idx_t;

  // What one lane reports for its phase.
  typedef struct packed {
    logic                           over;
    logic signed [CURRENT_BITS-1:0] cur;
    logic signed [CURRENT_BITS-1:0] clamped;
  } lane_res_t;

  // Request fields that travel beside the lane products.
  typedef struct packed {
    logic               valid;
    op_t                operation;
    logic               read_ok;
    logic [STAMP_W-1:0] timestamp;
    logic [BLANK_W-1:0] blank_len;
  } stage_ctrl_t;

endpackage

>>> hdl/pcom_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on pcom_pkg for field widths.
`timescale 1ns / 1ps

interface pcom_in_if
  import pcom_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [ADC_BITS-1:0] raw_a;
  logic [ADC_BITS-1:0] raw_b;
  logic [ADC_BITS-1:0] raw_c;
  logic                read_ok;
  logic [STAMP_W-1:0]  timestamp;
  logic [BLANK_W-1:0]  blank_len;

  modport source (output valid, operation, raw_a, raw_b, raw_c, read_ok, timestamp,
                  blank_len, input ready);
  modport sink (input valid, operation, raw_a, raw_b, raw_c, read_ok, timestamp,
                blank_len, output ready);
endinterface

interface pcom_out_if
  import pcom_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic [CURRENT_BITS-1:0] cur_a;
  logic [CURRENT_BITS-1:0] cur_b;
  logic [CURRENT_BITS-1:0] cur_c;
  logic [STAMP_W-1:0]      stamp_out;
  logic [COUNT_W-1:0]      sample_total;
  logic [COUNT_W-1:0]      error_total;
  logic                    quality_bad;
  logic [CURRENT_BITS-1:0] trip_a;
  logic [CURRENT_BITS-1:0] trip_b;
  logic [CURRENT_BITS-1:0] trip_c;

  modport source (output valid, status, cur_a, cur_b, cur_c, stamp_out, sample_total,
                  error_total, quality_bad, trip_a, trip_b, trip_c, input ready);
  modport sink (input valid, status, cur_a, cur_b, cur_c, stamp_out, sample_total,
                error_total, quality_bad, trip_a, trip_b, trip_c, output ready);
endinterface

>>> hdl/pcom_lane.sv
// One phase lane: offset removal and gain multiply, registered, then rounding,
// limit check, saturation and clamping. Depends on pcom_pkg.
`timescale 1ns / 1ps

module pcom_lane
  import pcom_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic [ADC_BITS-1:0] raw,
  input  logic [ADC_BITS-1:0] offset,
  input  logic [GAIN_W-1:0]   gain,
  input  logic [LIMIT_W-1:0]  limit,
  output lane_res_t           res
);

  localparam int DIFF_W = ADC_BITS + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int CAL_W  = PROD_W - FRAC_BITS;
  localparam int CMP_W  = ((CAL_W > CURRENT_BITS) ? CAL_W : CURRENT_BITS) + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [CMP_W-1:0]  CUR_MAX_X  = CMP_W'((1 << (CURRENT_BITS - 1)) - 1);
  localparam logic signed [CMP_W-1:0]  CUR_MIN_X  = -CUR_MAX_X - CMP_W'(1);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rounded;
  logic signed [CAL_W-1:0]  cal;
  logic signed [CMP_W-1:0]  cal_x;
  logic signed [CMP_W-1:0]  lim_x;
  logic signed [CMP_W-1:0]  clamp_x;
  logic                     above;
  logic                     below;

  // Offset removal and gain multiply, both operands widened to the full product.
  assign diff     = $signed({1'b0, raw}) - $signed({1'b0, offset});
  assign prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, gain}));

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  // Round to nearest with ties upward: add half, then floor by the shift.
  assign rounded = prod_r + ROUND_HALF;
  assign cal     = rounded[PROD_W-1:FRAC_BITS];
  assign cal_x   = CMP_W'(cal);
  assign lim_x   = CMP_W'($signed({1'b0, limit}));

  // Symmetric limit check.
  assign above = cal_x > lim_x;
  assign below = cal_x < -lim_x;

  // Clamp to the limit for the blanking path.
  always_comb begin
    if (above) begin
      clamp_x = lim_x;
    end else if (below) begin
      clamp_x = -lim_x;
    end else begin
      clamp_x = cal_x;
    end
  end

  // Saturate both forms into the current range.
  always_comb begin
    res.over = above || below;
    if (cal_x > CUR_MAX_X) begin
      res.cur = CUR_MAX_X[CURRENT_BITS-1:0];
    end else if (cal_x < CUR_MIN_X) begin
      res.cur = CUR_MIN_X[CURRENT_BITS-1:0];
    end else begin
      res.cur = cal_x[CURRENT_BITS-1:0];
    end
    if (clamp_x > CUR_MAX_X) begin
      res.clamped = CUR_MAX_X[CURRENT_BITS-1:0];
    end else if (clamp_x < CUR_MIN_X) begin
      res.clamped = CUR_MIN_X[CURRENT_BITS-1:0];
    end else begin
      res.clamped = clamp_x[CURRENT_BITS-1:0];
    end
  end

endmodule

>>> hdl/pcom_merge.sv
// Merge stage: combines the three lane results with the monitor state and
// holds the result register. Depends on pcom_pkg and the assertion header.
`timescale 1ns / 1ps

`include "phase_current_overcurrent_monitor_assert.svh"

module pcom_merge
  import pcom_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  stage_ctrl_t                    ctrl,
  input  lane_res_t                      res [NUM_PHASES],
  input  logic [LIMIT_W-1:0]             limit,
  input  logic [RUN_W-1:0]               run_len,
  output logic                           take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output status_t                        status,
  output logic [STAMP_W-1:0]             stamp,
  output logic signed [CURRENT_BITS-1:0] held [NUM_PHASES],
  output logic signed [CURRENT_BITS-1:0] trip [NUM_PHASES],
  output logic [COUNT_W-1:0]             sample_cnt,
  output logic [COUNT_W-1:0]             error_cnt,
  output logic                           quality_bad
);

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  logic                           out_v_r, out_v_nxt;
  status_t                        status_r, status_nxt;
  logic [STAMP_W-1:0]             stamp_r;
  logic signed [CURRENT_BITS-1:0] held_r [NUM_PHASES];
  logic signed [CURRENT_BITS-1:0] held_nxt [NUM_PHASES];
  logic signed [CURRENT_BITS-1:0] trip_r [NUM_PHASES];
  logic signed [CURRENT_BITS-1:0] trip_nxt [NUM_PHASES];
  logic [RUN_W-1:0]               run_r, run_nxt, run_inc;
  logic [BLANK_W-1:0]             blank_r, blank_nxt;
  logic [COUNT_W-1:0]             sample_cnt_r, sample_cnt_nxt;
  logic [COUNT_W-1:0]             error_cnt_r, error_cnt_nxt;
  logic                           quality_r, quality_nxt;
  logic [RUN_W-1:0]               need;
  logic                           any_over;
  logic                           load;

  // The result register frees up when it is empty or being taken.
  assign take = !out_v_r || out_ready;
  assign load = ctrl.valid && take;

  assign any_over = (limit != '0) && (res[0].over || res[1].over || res[2].over);
  assign need     = (run_len == '0) ? RUN_W'(1) : run_len;
  assign run_inc  = (run_r == RUN_MAX) ? run_r : run_r + RUN_W'(1);

  // Next state for one request.
  always_comb begin
    status_nxt     = ST_NEW;
    held_nxt       = held_r;
    trip_nxt       = trip_r;
    run_nxt        = run_r;
    blank_nxt      = blank_r;
    sample_cnt_nxt = sample_cnt_r;
    error_cnt_nxt  = error_cnt_r;
    quality_nxt    = quality_r;
    if (ctrl.operation == OP_BLANK) begin
      status_nxt = ST_BLANK;
      blank_nxt  = ctrl.blank_len;
      run_nxt    = '0;
    end else begin
      sample_cnt_nxt = sample_cnt_r + COUNT_W'(1);
      if (!ctrl.read_ok) begin
        status_nxt    = ST_ERR;
        error_cnt_nxt = error_cnt_r + COUNT_W'(1);
        quality_nxt   = 1'b1;
      end else if (any_over) begin
        for (int i = 0; i < NUM_PHASES; i++) begin
          trip_nxt[i] = res[i].cur;
        end
        if (blank_r != '0) begin
          // Overcurrent inside the blanking window passes on clamped.
          status_nxt  = ST_NEW;
          blank_nxt   = blank_r - BLANK_W'(1);
          run_nxt     = '0;
          quality_nxt = 1'b0;
          for (int i = 0; i < NUM_PHASES; i++) begin
            held_nxt[i] = res[i].clamped;
          end
        end else begin
          run_nxt = run_inc;
          if (run_inc >= need) begin
            status_nxt    = ST_TRIP;
            error_cnt_nxt = error_cnt_r + COUNT_W'(1);
            quality_nxt   = 1'b1;
          end else begin
            status_nxt = ST_HELD;
          end
        end
      end else begin
        status_nxt  = ST_NEW;
        blank_nxt   = (blank_r != '0) ? blank_r - BLANK_W'(1) : blank_r;
        run_nxt     = '0;
        quality_nxt = 1'b0;
        for (int i = 0; i < NUM_PHASES; i++) begin
          held_nxt[i] = res[i].cur;
        end
      end
    end
  end

  always_comb begin
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // Control state and monitor state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r      <= 1'b0;
      held_r       <= '{default: '0};
      trip_r       <= '{default: '0};
      run_r        <= '0;
      blank_r      <= '0;
      sample_cnt_r <= '0;
      error_cnt_r  <= '0;
      quality_r    <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (load) begin
        held_r       <= held_nxt;
        trip_r       <= trip_nxt;
        run_r        <= run_nxt;
        blank_r      <= blank_nxt;
        sample_cnt_r <= sample_cnt_nxt;
        error_cnt_r  <= error_cnt_nxt;
        quality_r    <= quality_nxt;
      end
    end
  end

  // Result payload that is not already part of the state.
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status_nxt;
      stamp_r  <= ctrl.timestamp;
    end
  end

  // State only changes with a new result, so it reads straight out.
  assign out_valid   = out_v_r;
  assign status      = status_r;
  assign stamp       = stamp_r;
  assign held        = held_r;
  assign trip        = trip_r;
  assign sample_cnt  = sample_cnt_r;
  assign error_cnt   = error_cnt_r;
  assign quality_bad = quality_r;

  // A stalled result freezes the state it reports.
  `PCOM_ASSERT_NEXT(a_stall_freezes_state, out_v_r && !out_ready, $stable(sample_cnt_r) && $stable(error_cnt_r))
  // Every sample request advances the sample count by exactly one.
  `PCOM_ASSERT_NEXT(a_sample_count_step, load && ctrl.operation == OP_SAMPLE, sample_cnt_r == COUNT_W'($past(sample_cnt_r) + COUNT_W'(1)))
  // Errors and trips always report bad quality.
  `PCOM_ASSERT_NOW(a_fault_quality, out_v_r && (status_r == ST_ERR || status_r == ST_TRIP), quality_r)
  // A blank set leaves no overcurrent run behind.
  `PCOM_ASSERT_NOW(a_blank_clears_run, out_v_r && status_r == ST_BLANK, run_r == '0)

endmodule

>>> hdl/phase_current_overcurrent_monitor.sv
// Top level of the phase current overcurrent monitor: configuration registers,
// request stage and three phase lanes feeding the merge stage.
// Depends on pcom_pkg, pcom_if, pcom_lane and pcom_merge.
//
//   Channel   Direction  Handshake            Contents
//   in_ch     sink       valid/ready          operation, three ADC codes, read_ok,
//                                             timestamp, blank_len
//   out_ch    source     valid/ready          status, currents, stamp, totals, trip
//   cfg_*     sink       cfg_we, no wait      register index and write data
//
// A request is registered in the request stage and lane multiply registers, then in the
// merge result register; one request per clock is sustained while out_ch is ready.
// Reset is synchronous and active low; all but the lane and payload registers reset.
// A stalled result keeps the merge stage and state frozen while one more request
// is taken into the lane registers.
`timescale 1ns / 1ps

module phase_current_overcurrent_monitor
  import pcom_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  pcom_in_if.sink               in_ch,
  pcom_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ADC_BITS-1:0]            offset_r [NUM_PHASES];
  logic [GAIN_W-1:0]              gain_r [NUM_PHASES];
  logic [LIMIT_W-1:0]             limit_r;
  logic [RUN_W-1:0]               run_len_r;
  stage_ctrl_t                    ctrl_r;
  logic                           ctrl_v_nxt;
  logic                           take;
  logic                           s1_load;
  logic [ADC_BITS-1:0]            raw [NUM_PHASES];
  lane_res_t                      res [NUM_PHASES];
  status_t                        status;
  logic signed [CURRENT_BITS-1:0] held [NUM_PHASES];
  logic signed [CURRENT_BITS-1:0] trip [NUM_PHASES];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '{default: OFFSET_RST};
      gain_r    <= '{default: GAIN_RST};
      limit_r   <= '0;
      run_len_r <= RUN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OFFSET_A: offset_r[0] <= cfg_data[ADC_BITS-1:0];
        CFG_OFFSET_B: offset_r[1] <= cfg_data[ADC_BITS-1:0];
        CFG_OFFSET_C: offset_r[2] <= cfg_data[ADC_BITS-1:0];
        CFG_GAIN_A:   gain_r[0]   <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_B:   gain_r[1]   <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_C:   gain_r[2]   <= cfg_data[GAIN_W-1:0];
        CFG_LIMIT:    limit_r     <= cfg_data[LIMIT_W-1:0];
        CFG_RUN_LEN:  run_len_r   <= cfg_data[RUN_W-1:0];
      endcase
    end
  end

  // Request stage: loads when empty or when the merge stage takes its content.
  assign s1_load     = !ctrl_r.valid || take;
  assign in_ch.ready = s1_load;
  assign ctrl_v_nxt  = s1_load ? in_ch.valid : ctrl_r.valid;

  // The valid bit resets; the payload only loads with the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else begin
      ctrl_r.valid <= ctrl_v_nxt;
    end
    if (s1_load) begin
      ctrl_r.operation <= op_t'(in_ch.operation);
      ctrl_r.read_ok   <= in_ch.read_ok;
      ctrl_r.timestamp <= in_ch.timestamp;
      ctrl_r.blank_len <= in_ch.blank_len;
    end
  end

  assign raw[0] = in_ch.raw_a;
  assign raw[1] = in_ch.raw_b;
  assign raw[2] = in_ch.raw_c;

  // One calibration lane per phase.
  for (genvar g = 0; g < NUM_PHASES; g++) begin : g_lane
    pcom_lane u_lane (
      .clk    (clk),
      .load   (s1_load),
      .raw    (raw[g]),
      .offset (offset_r[g]),
      .gain   (gain_r[g]),
      .limit  (limit_r),
      .res    (res[g])
    );
  end

  pcom_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl_r),
    .res         (res),
    .limit       (limit_r),
    .run_len     (run_len_r),
    .take        (take),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (status),
    .stamp       (out_ch.stamp_out),
    .held        (held),
    .trip        (trip),
    .sample_cnt  (out_ch.sample_total),
    .error_cnt   (out_ch.error_total),
    .quality_bad (out_ch.quality_bad)
  );

  // Result fields.
  assign out_ch.status = status;
  assign out_ch.cur_a  = held[0];
  assign out_ch.cur_b  = held[1];
  assign out_ch.cur_c  = held[2];
  assign out_ch.trip_a = trip[0];
  assign out_ch.trip_b = trip[1];
  assign out_ch.trip_c = trip[2];

endmodule

>>> test/tb.sv
// Testbench for the phase current overcurrent monitor: directed and random requests,
// with results checked against a cycle-free scoreboard model of the block.
// Depends on pcom_pkg, pcom_if and the phase_current_overcurrent_monitor RTL.
`timescale 1ns / 1ps

module tb;
  import pcom_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 6;
  localparam int SET_ITEMS = 125;
  localparam int PRESSURE_ITEMS = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int TIMEOUT_NS = 2_400_000;
  localparam int RUN_SAT = 255;
  localparam int MID_CODE = 1 << (ADC_BITS - 1);
  localparam int ADC_MAX = (1 << ADC_BITS) - 1;
  localparam longint CUR_HI = (longint'(1) << (CURRENT_BITS - 1)) - 1;
  localparam longint CUR_LO = -CUR_HI - 1;

  typedef struct {
    op_t                 operation;
    logic [ADC_BITS-1:0] raw[NUM_PHASES];
    logic                read_ok;
    logic [STAMP_W-1:0]  timestamp;
    logic [BLANK_W-1:0]  blank_len;
  } phase_req_t;

  typedef struct {
    status_t                        status;
    logic signed [CURRENT_BITS-1:0] cur[NUM_PHASES];
    logic [STAMP_W-1:0]             stamp;
    logic [COUNT_W-1:0]             samples;
    logic [COUNT_W-1:0]             faults;
    logic                           quality_bad;
    logic signed [CURRENT_BITS-1:0] trip[NUM_PHASES];
  } phase_res_t;

  typedef struct {
    logic [ADC_BITS-1:0] offset[NUM_PHASES];
    logic [GAIN_W-1:0]   gain[NUM_PHASES];
    logic [LIMIT_W-1:0]  limit;
    logic [RUN_W-1:0]    run_len;
  } monitor_cfg_t;

  // Scoreboard: tracks the monitor state and queues the expected result of each request.
  class overcurrent_scoreboard;
    monitor_cfg_t                   regs;
    logic signed [CURRENT_BITS-1:0] held[NUM_PHASES];
    logic signed [CURRENT_BITS-1:0] trip_store[NUM_PHASES];
    logic [RUN_W-1:0]               run_count;
    logic [BLANK_W-1:0]             blank_left;
    logic [COUNT_W-1:0]             sample_count;
    logic [COUNT_W-1:0]             fault_count;
    logic                           quality_bad;
    phase_res_t                     expected_q[$];
    int                             errors;

    function new();
      for (int i = 0; i < NUM_PHASES; i++) begin
        regs.offset[i] = OFFSET_RST;
        regs.gain[i] = GAIN_RST;
        held[i] = '0;
        trip_store[i] = '0;
      end
      regs.limit = '0;
      regs.run_len = RUN_RST;
      run_count = '0;
      blank_left = '0;
      sample_count = '0;
      fault_count = '0;
      quality_bad = 1'b0;
      errors = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_OFFSET_A: regs.offset[0] = value[ADC_BITS-1:0];
        CFG_OFFSET_B: regs.offset[1] = value[ADC_BITS-1:0];
        CFG_OFFSET_C: regs.offset[2] = value[ADC_BITS-1:0];
        CFG_GAIN_A:   regs.gain[0] = value[GAIN_W-1:0];
        CFG_GAIN_B:   regs.gain[1] = value[GAIN_W-1:0];
        CFG_GAIN_C:   regs.gain[2] = value[GAIN_W-1:0];
        CFG_LIMIT:    regs.limit = value[LIMIT_W-1:0];
        CFG_RUN_LEN:  regs.run_len = value[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    // (raw - offset) * gain in Q4.12, rounded to nearest with ties upward.
    function longint phase_current(logic [ADC_BITS-1:0] raw, logic [ADC_BITS-1:0] off,
                                   logic [GAIN_W-1:0] gain);
      longint prod;
      prod = (longint'(raw) - longint'(off)) * longint'(gain) + (longint'(1) << (FRAC_BITS - 1));
      return prod >>> FRAC_BITS;
    endfunction

    function logic signed [CURRENT_BITS-1:0] saturate(longint v);
      if (v > CUR_HI) return CURRENT_BITS'(CUR_HI);
      if (v < CUR_LO) return CURRENT_BITS'(CUR_LO);
      return CURRENT_BITS'(v);
    endfunction

    function longint clamp_to_limit(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(phase_req_t r);
      phase_res_t  want;
      longint      cur[NUM_PHASES];
      longint      lim;
      bit          over;
      int unsigned need;
      want.stamp = r.timestamp;
      if (r.operation == OP_BLANK) begin
        blank_left = r.blank_len;
        run_count = '0;
        want.status = ST_BLANK;
      end else begin
        sample_count++;
        if (!r.read_ok) begin
          fault_count++;
          quality_bad = 1'b1;
          want.status = ST_ERR;
        end else begin
          lim = longint'(regs.limit);
          over = 1'b0;
          for (int i = 0; i < NUM_PHASES; i++) begin
            cur[i] = phase_current(r.raw[i], regs.offset[i], regs.gain[i]);
            if (cur[i] > lim || cur[i] < -lim) over = 1'b1;
          end
          if (lim > 0 && over) begin
            // Overcurrent: the trip store always takes the unclamped currents.
            for (int i = 0; i < NUM_PHASES; i++) trip_store[i] = saturate(cur[i]);
            if (blank_left != 0) begin
              blank_left--;
              run_count = '0;
              for (int i = 0; i < NUM_PHASES; i++)
                held[i] = saturate(clamp_to_limit(cur[i], lim));
              quality_bad = 1'b0;
              want.status = ST_NEW;
            end else begin
              if (run_count != RUN_SAT) run_count++;
              need = (regs.run_len == 0) ? 1 : regs.run_len;
              if (run_count >= need) begin
                fault_count++;
                quality_bad = 1'b1;
                want.status = ST_TRIP;
              end else begin
                want.status = ST_HELD;
              end
            end
          end else begin
            if (blank_left != 0) blank_left--;
            run_count = '0;
            quality_bad = 1'b0;
            for (int i = 0; i < NUM_PHASES; i++) held[i] = saturate(cur[i]);
            want.status = ST_NEW;
          end
        end
      end
      for (int i = 0; i < NUM_PHASES; i++) begin
        want.cur[i] = held[i];
        want.trip[i] = trip_store[i];
      end
      want.samples = sample_count;
      want.faults = fault_count;
      want.quality_bad = quality_bad;
      expected_q.push_back(want);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(phase_res_t got);
      phase_res_t want;
      string      tag[NUM_PHASES];
      tag = '{"a", "b", "c"};
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request waiting, status %0d, stamp %h",
                 $time, got.status, got.stamp);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("status", want.status, got.status);
      compare("stamp_out", want.stamp, got.stamp);
      compare("sample_total", want.samples, got.samples);
      compare("error_total", want.faults, got.faults);
      compare("quality_bad", want.quality_bad, got.quality_bad);
      for (int i = 0; i < NUM_PHASES; i++) begin
        compare({"cur_", tag[i]}, want.cur[i], got.cur[i]);
        compare({"trip_", tag[i]}, want.trip[i], got.trip[i]);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    hold_req_count = 0;
  int                    hold_seen = 0;
  int                    hold_left = 0;
  monitor_cfg_t          active;
  overcurrent_scoreboard sb = new();

  pcom_in_if  in_ch ();
  pcom_out_if out_ch ();

  phase_current_overcurrent_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side readiness: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen <= hold_req_count;
      hold_left <= 0;
    end else if (hold_req_count != hold_seen) begin
      hold_seen <= hold_req_count;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted request is handed to the scoreboard.
  always @(posedge clk) begin : request_monitor
    phase_req_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.operation = op_t'(in_ch.operation);
      seen.raw[0] = in_ch.raw_a;
      seen.raw[1] = in_ch.raw_b;
      seen.raw[2] = in_ch.raw_c;
      seen.read_ok = in_ch.read_ok;
      seen.timestamp = in_ch.timestamp;
      seen.blank_len = in_ch.blank_len;
      sb.note_request(seen);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    phase_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = status_t'(out_ch.status);
      got.cur[0] = out_ch.cur_a;
      got.cur[1] = out_ch.cur_b;
      got.cur[2] = out_ch.cur_c;
      got.stamp = out_ch.stamp_out;
      got.samples = out_ch.sample_total;
      got.faults = out_ch.error_total;
      got.quality_bad = out_ch.quality_bad;
      got.trip[0] = out_ch.trip_a;
      got.trip[1] = out_ch.trip_b;
      got.trip[2] = out_ch.trip_c;
      sb.check_result(got);
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Valid stays high from one request to the next unless the sender idles.
  task automatic push_request(phase_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= r.operation;
    in_ch.raw_a <= r.raw[0];
    in_ch.raw_b <= r.raw[1];
    in_ch.raw_c <= r.raw[2];
    in_ch.read_ok <= r.read_ok;
    in_ch.timestamp <= r.timestamp;
    in_ch.blank_len <= r.blank_len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(monitor_cfg_t s);
    cfg_write(CFG_OFFSET_A, CFG_DATA_W'(s.offset[0]));
    cfg_write(CFG_OFFSET_B, CFG_DATA_W'(s.offset[1]));
    cfg_write(CFG_OFFSET_C, CFG_DATA_W'(s.offset[2]));
    cfg_write(CFG_GAIN_A, CFG_DATA_W'(s.gain[0]));
    cfg_write(CFG_GAIN_B, CFG_DATA_W'(s.gain[1]));
    cfg_write(CFG_GAIN_C, CFG_DATA_W'(s.gain[2]));
    cfg_write(CFG_LIMIT, CFG_DATA_W'(s.limit));
    cfg_write(CFG_RUN_LEN, CFG_DATA_W'(s.run_len));
    cfg_we <= 1'b0;
    active = s;
  endtask

  function automatic phase_req_t fresh_request(op_t op);
    phase_req_t r;
    r.operation = op;
    for (int i = 0; i < NUM_PHASES; i++) r.raw[i] = ADC_BITS'($urandom);
    r.read_ok = 1'b1;
    r.timestamp = $urandom;
    r.blank_len = BLANK_W'($urandom);
    return r;
  endfunction

  function automatic phase_req_t codes(logic [ADC_BITS-1:0] a, logic [ADC_BITS-1:0] b,
                                       logic [ADC_BITS-1:0] c);
    phase_req_t r;
    r = fresh_request(OP_SAMPLE);
    r.raw[0] = a;
    r.raw[1] = b;
    r.raw[2] = c;
    return r;
  endfunction

  // A code close enough to the offset that the current mostly stays under the limit.
  function automatic logic [ADC_BITS-1:0] near_code(logic [ADC_BITS-1:0] center);
    int span;
    int v;
    span = (active.limit == 0) ? 64 : int'(active.limit) / 3 + 1;
    if (span > MID_CODE) span = MID_CODE;
    v = int'(center) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return ADC_BITS'(v);
  endfunction

  // Codes near the far end of the ADC range on every phase, to drive an overcurrent.
  function automatic phase_req_t loud_request();
    phase_req_t r;
    r = fresh_request(OP_SAMPLE);
    for (int i = 0; i < NUM_PHASES; i++)
      r.raw[i] = (active.offset[i] < MID_CODE) ? ADC_BITS'(ADC_MAX - $urandom_range(63))
                                               : ADC_BITS'($urandom_range(63));
    if ($urandom_range(99) < 5) r.read_ok = 1'b0;
    return r;
  endfunction

  // Extreme sets push registers to their ends; the others keep currents near the limit.
  function automatic monitor_cfg_t random_settings(bit extreme, int phase_no);
    monitor_cfg_t s;
    for (int i = 0; i < NUM_PHASES; i++) begin
      if (extreme) begin
        s.offset[i] = $urandom_range(1) ? ADC_BITS'(ADC_MAX) : '0;
        s.gain[i] = $urandom_range(1) ? '1 : GAIN_W'(1);
      end else begin
        s.offset[i] = ($urandom_range(4) == 0) ? ADC_BITS'($urandom)
                                               : ADC_BITS'($urandom_range(2600, 1500));
        s.gain[i] = ($urandom_range(4) == 0) ? GAIN_W'($urandom_range(65535, 1))
                                             : GAIN_W'($urandom_range(8192, 2048));
      end
    end
    if (extreme) begin
      s.gain[0] = '1;
      case (phase_no)
        0: begin
          s.limit = LIMIT_W'(1);
          s.run_len = '1;
        end
        1: begin
          s.limit = '1;
          s.run_len = '0;
        end
        default: begin
          s.limit = '0;
          s.run_len = RUN_W'(1);
        end
      endcase
    end else begin
      s.limit = LIMIT_W'($urandom_range(700, 20));
      s.run_len = RUN_W'($urandom_range(6, 1));
    end
    return s;
  endfunction

  // Mostly well-formed traffic: quiet samples, overcurrent runs, blanking and read faults.
  task automatic run_random(int count);
    phase_req_t r;
    int         sent;
    int         pick;
    int         need;
    int         burst;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        r = fresh_request(OP_BLANK);
        if ($urandom_range(9) < 7) r.blank_len = BLANK_W'($urandom_range(6));
        push_request(r);
        sent++;
      end else if (pick < 18) begin
        r = fresh_request(OP_SAMPLE);
        r.read_ok = 1'b0;
        push_request(r);
        sent++;
      end else if (pick < 30) begin
        need = (active.run_len == 0) ? 1 : int'(active.run_len);
        burst = $urandom_range(need + 2, 1);
        repeat (burst) begin
          push_request(loud_request());
          sent++;
        end
      end else begin
        r = fresh_request(OP_SAMPLE);
        if ($urandom_range(9) < 6)
          for (int i = 0; i < NUM_PHASES; i++) r.raw[i] = near_code(active.offset[i]);
        push_request(r);
        sent++;
      end
    end
  endtask

  // Directed requests: field extremes, every status, rounding ties and edge settings.
  task automatic directed_checks();
    monitor_cfg_t s;
    phase_req_t   r;
    // Reset settings: detection disabled, unity gain.
    r = codes(0, ADC_MAX, MID_CODE);
    r.timestamp = '0;
    r.blank_len = '0;
    push_request(r);
    r = codes(ADC_MAX, 0, MID_CODE - 1);
    r.timestamp = '1;
    r.blank_len = '1;
    push_request(r);
    r = fresh_request(OP_SAMPLE);
    r.read_ok = 1'b0;
    push_request(r);
    r = fresh_request(OP_BLANK);
    r.blank_len = '0;
    push_request(r);
    wait_drained();

    // Saturating gains, zero gain on phase C, widest limit, run of three to trip.
    s.offset = '{12'd0, 12'd4095, 12'd2048};
    s.gain = '{16'hFFFF, 16'hFFFF, 16'd0};
    s.limit = '1;
    s.run_len = RUN_W'(3);
    apply_settings(s);
    repeat (4) push_request(codes(ADC_MAX, 0, 1234));
    r = fresh_request(OP_SAMPLE);
    r.read_ok = 1'b0;
    push_request(r);
    push_request(codes(0, ADC_MAX, 77));
    // Blanking window of two: two clamped samples, then a held one.
    r = fresh_request(OP_BLANK);
    r.blank_len = BLANK_W'(2);
    push_request(r);
    repeat (3) push_request(codes(ADC_MAX, 0, 5));
    r = fresh_request(OP_BLANK);
    r.blank_len = BLANK_W'(1);
    push_request(r);
    push_request(codes(0, ADC_MAX, 9));
    wait_drained();

    // Smallest limit, zero run length, half gain on phase B for rounding ties.
    s.offset = '{12'd2048, 12'd2048, 12'd2048};
    s.gain = '{16'd4096, 16'd2048, 16'd4096};
    s.limit = LIMIT_W'(1);
    s.run_len = '0;
    apply_settings(s);
    push_request(codes(2049, 2047, 2048));
    push_request(codes(2049, 2049, 2048));
    push_request(codes(2050, 2048, 2048));
    push_request(codes(2048, 2048, 2046));
    push_request(codes(2047, 2048, 2049));
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_OFFSET_A;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_SAMPLE;
    in_ch.raw_a <= '0;
    in_ch.raw_b <= '0;
    in_ch.raw_c <= '0;
    in_ch.read_ok <= 1'b0;
    in_ch.timestamp <= '0;
    in_ch.blank_len <= '0;
    active = sb.regs;
    set_idling(16, 83);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    directed_checks();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: set_idling(16, 83);
        1: set_idling(83, 16);
        default: set_idling(0, 0);
      endcase
      if (p == 2) begin
        // Stall the result side while requests keep coming, then let it all drain.
        hold_req_count <= hold_req_count + 1;
        run_random(PRESSURE_ITEMS);
        wait_drained();
      end
      for (int k = 0; k < 3; k++) begin
        wait_drained();
        apply_settings(random_settings(k == 1, p));
        run_random(SET_ITEMS);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/pcom_pkg.sv
hdl/pcom_if.sv
hdl/pcom_lane.sv
hdl/pcom_merge.sv
hdl/phase_current_overcurrent_monitor.sv
test/tb.sv
